FILE: hw/rtl/shd_pkg.sv
// Shared types and constants for the session header demultiplexer.
package shd_pkg;

	// Header flag bits and the mask that must be clear for a class to apply
	localparam logic [7:0] FLAG_SYN   = 8'h80;
	localparam logic [7:0] FLAG_FIN   = 8'h40;
	localparam logic [7:0] FLAG_PUSH  = 8'h20;
	localparam logic [7:0] FLAG_RESET = 8'h10;
	localparam logic [7:0] LOW_NIBBLE = 8'h0f;

	// Entry modes
	localparam logic [2:0] MODE_READABLE  = 3'd0;
	localparam logic [2:0] MODE_WRITEABLE = 3'd1;
	localparam logic [2:0] MODE_DUPLEX_IO = 3'd2;
	localparam logic [2:0] MODE_DUPLEX    = 3'd4;

	// Close actions
	localparam logic [1:0] CLOSE_NONE = 2'd0;
	localparam logic [1:0] CLOSE_READ = 2'd1;
	localparam logic [1:0] CLOSE_BOTH = 2'd2;

	// Opcodes
	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_INSTALL = 1'b1;

	// One table entry as stored in the entry memory (present bits live in flops)
	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] session;
		logic        assigned;
		logic        syn_seen;
		logic [1:0]  close;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Incoming transaction
	typedef struct packed {
		logic        opcode;
		logic [7:0]  packet_flags;
		logic [23:0] packet_session;
		logic [31:0] packet_length;
		logic [2:0]  install_index;
		logic [2:0]  install_mode;
		logic        install_has_id;
	} in_t;

	// Outgoing transaction
	typedef struct packed {
		logic        matched;
		logic [2:0]  target_entry;
		logic        to_discard;
		logic        data_follows;
		logic [31:0] bytes_to_take;
		logic [1:0]  close_action;
		logic        syn_reply;
		logic        reset_reply;
		logic [23:0] reply_session;
		logic        got_reset;
	} out_t;

	// Result handoff from the sequencer to the output stage
	typedef struct packed {
		logic valid;
		out_t data;
	} res_t;

	// Header class after decode
	typedef enum logic [2:0] {
		CLS_INSTALL,
		CLS_SYN,
		CLS_FIN,
		CLS_PUSH,
		CLS_RESET,
		CLS_DATA,
		CLS_FUNKY
	} cls_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic logic flag_class(input logic [7:0] flags, input logic [7:0] bit_m);
		return (flags & (bit_m | LOW_NIBBLE)) == bit_m;
	endfunction

endpackage

FILE: hw/rtl/shd_if.sv
// Channel interfaces for header input and routing result output.
interface shd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  packet_flags;
	logic [23:0] packet_session;
	logic [31:0] packet_length;
	logic [2:0]  install_index;
	logic [2:0]  install_mode;
	logic        install_has_id;

	modport source (
		output valid, opcode, packet_flags, packet_session, packet_length,
		output install_index, install_mode, install_has_id,
		input  ready
	);
	modport sink (
		input  valid, opcode, packet_flags, packet_session, packet_length,
		input  install_index, install_mode, install_has_id,
		output ready
	);
endinterface

interface shd_out_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [2:0]  target_entry;
	logic        to_discard;
	logic        data_follows;
	logic [31:0] bytes_to_take;
	logic [1:0]  close_action;
	logic        syn_reply;
	logic        reset_reply;
	logic [23:0] reply_session;
	logic        got_reset;

	modport source (
		output valid, matched, target_entry, to_discard, data_follows, bytes_to_take,
		output close_action, syn_reply, reset_reply, reply_session, got_reset,
		input  ready
	);
	modport sink (
		input  valid, matched, target_entry, to_discard, data_follows, bytes_to_take,
		input  close_action, syn_reply, reset_reply, reply_session, got_reset,
		output ready
	);
endinterface

FILE: hw/rtl/shd_ram.sv
// Generic single-write, single-read memory with registered read data.
module shd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/shd_ctrl.sv
// Sequencer: decodes a transaction, scans the entry memory and writes back.
module shd_ctrl import shd_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output res_t res,
	input  logic res_ready
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = AW + 1;
	localparam int IW = (AW > 3) ? AW : 3;
	localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	state_t            state_q;
	in_t               item_q;
	cls_t              cls_q;
	cls_t              cls_d;
	logic              pass_q;
	logic [CW-1:0]     addr_q;
	logic              chk_s1;
	logic [AW-1:0]     chk_addr_s1;
	logic              found_q;
	logic [AW-1:0]     found_idx_q;
	entry_t            found_ent_q;
	logic [ENTRIES-1:0] present_q;
	logic              reset_seen_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t            rd_ent;
	entry_t            wr_ent;
	logic              rd_writable;
	logic              rd_sess_eq;
	logic              rd_present;
	logic              hit;
	logic              idx_ok;
	logic [IW-1:0]     idx_w;
	logic              accept;
	logic              len_nz;
	logic              readable_data;

	shd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode the flag class of the incoming transaction
	always_comb begin
		if (in_item.opcode == OP_INSTALL) begin
			cls_d = CLS_INSTALL;
		end else if (flag_class(in_item.packet_flags, FLAG_SYN)) begin
			cls_d = CLS_SYN;
		end else if (flag_class(in_item.packet_flags, FLAG_FIN)) begin
			cls_d = CLS_FIN;
		end else if (flag_class(in_item.packet_flags, FLAG_PUSH)) begin
			cls_d = CLS_PUSH;
		end else if (flag_class(in_item.packet_flags, FLAG_RESET)) begin
			cls_d = CLS_RESET;
		end else if (in_item.packet_flags == 8'h00) begin
			cls_d = CLS_DATA;
		end else begin
			cls_d = CLS_FUNKY;
		end
	end

	assign idx_ok = ({29'd0, in_item.install_index} < 32'(ENTRIES));
	assign idx_w  = IW'(item_q.install_index);

	// Match test on the entry read back from memory
	assign rd_ent      = entry_t'(ram_rdata);
	assign rd_present  = present_q[chk_addr_s1];
	assign rd_writable = (rd_ent.mode >= MODE_WRITEABLE) && (rd_ent.mode <= MODE_DUPLEX);
	assign rd_sess_eq  = (rd_ent.session == item_q.packet_session);

	always_comb begin
		case (cls_q)
			CLS_SYN: begin
				if (!pass_q) begin
					hit = rd_present && !rd_ent.syn_seen && rd_writable
						&& rd_ent.assigned && rd_sess_eq;
				end else begin
					hit = rd_present && !rd_ent.syn_seen && rd_writable && !rd_ent.assigned;
				end
			end
			CLS_FIN: begin
				hit = rd_present && rd_ent.syn_seen && rd_ent.assigned && rd_sess_eq
					&& rd_writable;
			end
			CLS_RESET: begin
				hit = rd_present && rd_ent.syn_seen && rd_ent.assigned && rd_sess_eq
					&& (rd_ent.mode <= MODE_DUPLEX);
			end
			CLS_DATA: begin
				hit = rd_present && rd_ent.assigned && rd_sess_eq;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	// Build the write-back entry
	always_comb begin
		wr_ent    = found_ent_q;
		ram_waddr = found_idx_q;
		case (cls_q)
			CLS_INSTALL: begin
				wr_ent.mode     = item_q.install_mode;
				wr_ent.assigned = item_q.install_has_id;
				wr_ent.session  = item_q.install_has_id ? item_q.packet_session : 24'd0;
				wr_ent.syn_seen = 1'b0;
				wr_ent.close    = CLOSE_NONE;
				ram_waddr       = AW'(idx_w);
			end
			CLS_SYN: begin
				wr_ent.assigned = 1'b1;
				wr_ent.session  = item_q.packet_session;
				wr_ent.syn_seen = 1'b1;
			end
			CLS_FIN: begin
				wr_ent.close = CLOSE_READ;
			end
			CLS_RESET: begin
				wr_ent.close = CLOSE_BOTH;
			end
			default: begin
				wr_ent = found_ent_q;
			end
		endcase
	end

	assign ram_we    = (state_q == ST_WRITE);
	assign ram_wdata = wr_ent;
	assign ram_raddr = addr_q[AW-1:0];

	// Sequencer and scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cls_q        <= CLS_DATA;
			pass_q       <= 1'b0;
			addr_q       <= '0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			present_q    <= '0;
			reset_seen_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cls_q   <= cls_d;
						pass_q  <= 1'b0;
						addr_q  <= '0;
						chk_s1  <= 1'b0;
						found_q <= 1'b0;
						case (cls_d)
							CLS_INSTALL: state_q <= idx_ok ? ST_WRITE : ST_DONE;
							CLS_SYN, CLS_FIN, CLS_RESET, CLS_DATA: state_q <= ST_SCAN;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					// stop on the first hit, close the pass after the last entry,
					// otherwise issue the next read while entries remain
					if (chk_s1 && hit) begin
						found_q <= 1'b1;
						chk_s1  <= 1'b0;
						state_q <= (cls_q == CLS_DATA) ? ST_DONE : ST_WRITE;
					end else if (chk_s1 && chk_addr_s1 == LAST_IDX) begin
						chk_s1 <= 1'b0;
						if (cls_q == CLS_SYN && !pass_q) begin
							pass_q <= 1'b1;
							addr_q <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (addr_q < CNT_END) begin
						chk_s1 <= 1'b1;
						addr_q <= addr_q + CW'(1);
					end else begin
						chk_s1 <= 1'b0;
					end
				end
				ST_WRITE: begin
					if (cls_q == CLS_INSTALL) begin
						present_q[AW'(idx_w)] <= 1'b1;
					end
					if (cls_q == CLS_RESET) begin
						reset_seen_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: latched transaction, scan address and the hit entry
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		chk_addr_s1 <= addr_q[AW-1:0];
		if (state_q == ST_SCAN && chk_s1 && hit) begin
			found_idx_q <= chk_addr_s1;
			found_ent_q <= rd_ent;
		end
	end

	// Assemble the result
	assign len_nz        = (item_q.packet_length != 32'd0);
	assign readable_data = found_q && len_nz && (found_ent_q.mode == MODE_READABLE);

	always_comb begin
		res.valid = (state_q == ST_DONE);
		res.data  = '0;
		res.data.got_reset = reset_seen_q;
		if (cls_q != CLS_INSTALL) begin
			res.data.matched       = found_q;
			res.data.target_entry  = found_q ? 3'(found_idx_q) : 3'd0;
			res.data.to_discard    = !found_q || readable_data;
			res.data.data_follows  = len_nz;
			res.data.bytes_to_take = item_q.packet_length;
			res.data.reset_reply   = readable_data;
			res.data.syn_reply     = found_q && (cls_q == CLS_SYN)
				&& (found_ent_q.mode == MODE_DUPLEX_IO);
			if (found_q && cls_q == CLS_FIN) begin
				res.data.close_action = CLOSE_READ;
			end else if (found_q && cls_q == CLS_RESET) begin
				res.data.close_action = CLOSE_BOTH;
			end
			if (res.data.syn_reply || res.data.reset_reply) begin
				res.data.reply_session = item_q.packet_session;
			end
		end
	end

endmodule

FILE: hw/rtl/session_header_demux.sv
// Top level: session header demultiplexer with entry table and result register.
//
//  channel | modport      | moves
//  --------+--------------+-------------------------------------------------
//  hdr     | shd_in_if    | header or entry install, one per transaction
//  res     | shd_out_if   | routing result, exactly one per input transaction
//
// An input transaction is taken only while the sequencer is idle. Installs,
// PUSH and odd flags skip the scan; data, FIN, RESET and SYN scan the entry
// memory read port one entry per cycle, and SYN may take two passes. Each
// transaction is done before the next one is accepted.
// Reset clears all entries, the scan state and the sticky reset flag; no
// clearing pass is needed. The result register lets the next transaction
// enter while a result waits on a stalled res channel.
module session_header_demux import shd_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	shd_in_if.sink    hdr,
	shd_out_if.source res
);

	in_t  in_item;
	res_t ctrl_res;
	logic ctrl_ready;
	logic out_valid_q;
	out_t out_q;

	assign in_item.opcode         = hdr.opcode;
	assign in_item.packet_flags   = hdr.packet_flags;
	assign in_item.packet_session = hdr.packet_session;
	assign in_item.packet_length  = hdr.packet_length;
	assign in_item.install_index  = hdr.install_index;
	assign in_item.install_mode   = hdr.install_mode;
	assign in_item.install_has_id = hdr.install_has_id;

	shd_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hdr.valid),
		.in_ready  (hdr.ready),
		.in_item   (in_item),
		.res       (ctrl_res),
		.res_ready (ctrl_ready)
	);

	// Take a new result when the register is empty or being drained
	assign ctrl_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_ready) begin
			out_valid_q <= ctrl_res.valid;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (ctrl_ready && ctrl_res.valid) begin
			out_q <= ctrl_res.data;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.matched       = out_q.matched;
	assign res.target_entry  = out_q.target_entry;
	assign res.to_discard    = out_q.to_discard;
	assign res.data_follows  = out_q.data_follows;
	assign res.bytes_to_take = out_q.bytes_to_take;
	assign res.close_action  = out_q.close_action;
	assign res.syn_reply     = out_q.syn_reply;
	assign res.reset_reply   = out_q.reset_reply;
	assign res.reply_session = out_q.reply_session;
	assign res.got_reset     = out_q.got_reset;

endmodule
